// File: rtl/core/bfa_pkg.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator package
// Shared sizes, operation and status codes, and the command and status
// structures that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package bfa_pkg;

    localparam int MAX_FRAMES  = 4096;
    localparam int FRAME_BYTES = 4096;
    localparam int WORD_BITS   = 32;

    localparam int MAP_WORDS   = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
    localparam int WORD_IDX_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_IDX_W   = $clog2(WORD_BITS);
    localparam int FRAME_IDX_W = WORD_IDX_W + BIT_IDX_W;
    localparam int FRAME_SHIFT = $clog2(FRAME_BYTES);

    localparam int KIND_W      = 2;
    localparam int ADDR_W      = 32;
    localparam int FADDR_W     = 24;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 13;

    localparam int PAGE_W      = ADDR_W - FRAME_SHIFT;
    localparam int LIMIT_W     = $clog2(MAX_FRAMES + 1);
    localparam int CMP_W       = (COUNT_W > LIMIT_W) ? COUNT_W : LIMIT_W;
    localparam int RANGE_W     = (PAGE_W > LIMIT_W) ? PAGE_W : LIMIT_W;

    localparam logic [COUNT_W-1:0] FRAME_COUNT_RESET = COUNT_W'(4096);

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_OOM   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic                start_search;
        logic                free_read;
        logic                next_word;
        logic                alloc_write;
        logic                free_write;
        logic                clear_map;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_has_addr;
    } bfa_cmd_t;

    typedef struct packed {
        logic limit_zero;
        logic free_in_range;
        logic found;
        logic last_word;
    } bfa_stat_t;

endpackage

// File: rtl/core/bfa_if.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator channels
// Request and response channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bfa_req_if;
    logic                         valid;
    logic                         ready;
    logic [bfa_pkg::KIND_W-1:0]   kind;
    logic [bfa_pkg::ADDR_W-1:0]   address;

    modport source (output valid, output kind, output address, input ready);
    modport sink   (input valid, input kind, input address, output ready);
endinterface

interface bfa_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [bfa_pkg::FADDR_W-1:0]  frame_address;
    logic [bfa_pkg::STATUS_W-1:0] status;

    modport source (output valid, output frame_address, output status, input ready);
    modport sink   (input valid, input frame_address, input status, output ready);
endinterface

// File: rtl/core/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator
// Allocate, free and initialize operations over a used/free frame bitmap.
// ----------------------------------------------------------------------------
// Allocate reads map word 0 on acceptance, then scans in S_SCAN one map word
// per cycle through the single read port of the map memory until a free frame
// is found and marked or the last usable word is checked. Free reads the word
// and clears its bit in S_FREE_WR; initialize and rejected requests go to S_DONE.
// One request is in flight at a time; the next one is taken once its response
// is loaded. Reset sets the frame count to 4096 and clears every valid bit at once.
module bitmap_frame_allocator (
    input  logic                         clk,
    input  logic                         rst_n,
    bfa_req_if.sink                      req,
    bfa_rsp_if.source                    rsp,
    input  logic                         cfg_write,
    input  logic [bfa_pkg::COUNT_W-1:0]  cfg_data
);

    bfa_pkg::bfa_cmd_t  cmd;
    bfa_pkg::bfa_stat_t stat;

    bfa_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    bfa_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_data      (cfg_data),
        .req_address   (req.address),
        .cmd           (cmd),
        .stat          (stat),
        .frame_address (rsp.frame_address),
        .status        (rsp.status)
    );

endmodule

// File: rtl/core/bfa_datapath.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator datapath
// Holds the frame count, the used map memory with per-word valid bits, the
// word scan logic and the response register.
// ----------------------------------------------------------------------------
module bfa_datapath (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [bfa_pkg::COUNT_W-1:0]   cfg_data,
    input  logic [bfa_pkg::ADDR_W-1:0]    req_address,
    input  bfa_pkg::bfa_cmd_t             cmd,
    output bfa_pkg::bfa_stat_t            stat,
    output logic [bfa_pkg::FADDR_W-1:0]   frame_address,
    output logic [bfa_pkg::STATUS_W-1:0]  status
);

    localparam int WB = bfa_pkg::WORD_BITS;
    localparam int WW = bfa_pkg::WORD_IDX_W;
    localparam int BW = bfa_pkg::BIT_IDX_W;
    localparam int FW = bfa_pkg::FRAME_IDX_W;

    logic [WB-1:0]                   mem [bfa_pkg::MAP_WORDS];
    logic [bfa_pkg::MAP_WORDS-1:0]   valid_reg;
    logic [bfa_pkg::COUNT_W-1:0]     frame_count_reg;
    logic [WB-1:0]                   rd_data_reg;
    logic                            rd_valid_reg;
    logic [WW-1:0]                   word_reg;
    logic [WW-1:0]                   word_next;
    logic [BW-1:0]                   bit_reg;
    logic [FW-1:0]                   found_frame_reg;
    logic [bfa_pkg::FADDR_W-1:0]     frame_address_reg;
    logic [bfa_pkg::STATUS_W-1:0]    status_reg;

    logic [bfa_pkg::CMP_W-1:0]       count_ext;
    logic [bfa_pkg::CMP_W-1:0]       limit_ext;
    logic [bfa_pkg::LIMIT_W-1:0]     limit;
    logic [FW-1:0]                   limit_m1;
    logic [bfa_pkg::PAGE_W-1:0]      page;
    logic [FW-1:0]                   page_frame;
    logic                            rd_en;
    logic [WW-1:0]                   rd_addr;
    logic [WB-1:0]                   word_val;
    logic [WB-1:0]                   allow_mask;
    logic [WB-1:0]                   free_mask;
    logic [BW-1:0]                   found_bit;
    logic                            mem_we;
    logic [WB-1:0]                   wr_word;

    function automatic logic [BW-1:0] lowest_set(input logic [WB-1:0] m);
        logic [BW-1:0] idx;
        idx = '0;
        for (int i = WB - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                idx = BW'(i);
            end
        end
        return idx;
    endfunction

    assign count_ext  = bfa_pkg::CMP_W'(frame_count_reg);
    assign limit_ext  = (count_ext > bfa_pkg::CMP_W'(bfa_pkg::MAX_FRAMES))
                        ? bfa_pkg::CMP_W'(bfa_pkg::MAX_FRAMES) : count_ext;
    assign limit      = bfa_pkg::LIMIT_W'(limit_ext);
    assign limit_m1   = FW'(limit - 1'b1);

    assign page       = req_address[bfa_pkg::ADDR_W-1:bfa_pkg::FRAME_SHIFT];
    assign page_frame = FW'(page);

    assign rd_en = cmd.start_search | cmd.free_read | cmd.next_word;

    always_comb
    begin
        priority if (cmd.free_read)
        begin
            rd_addr = page_frame[FW-1:BW];
        end
        else if (cmd.next_word)
        begin
            rd_addr = WW'(word_reg + 1'b1);
        end
        else
        begin
            rd_addr = '0;
        end
    end

    assign word_next = rd_addr;

    assign word_val = rd_valid_reg ? rd_data_reg
                    : ((word_reg == '0) ? WB'(1) : '0);

    always_comb
    begin
        for (int b = 0; b < WB; b++)
        begin
            allow_mask[b] = (word_reg != limit_m1[FW-1:BW])
                            || (BW'(b) <= limit_m1[BW-1:0]);
        end
    end

    assign free_mask = ~word_val & allow_mask;
    assign found_bit = lowest_set(free_mask);

    assign stat.limit_zero    = (frame_count_reg == '0);
    assign stat.free_in_range = bfa_pkg::RANGE_W'(page) < bfa_pkg::RANGE_W'(limit);
    assign stat.found         = |free_mask;
    assign stat.last_word     = (word_reg == limit_m1[FW-1:BW]);

    assign mem_we  = cmd.alloc_write | cmd.free_write;
    assign wr_word = cmd.alloc_write ? (word_val | (WB'(1) << found_bit))
                                     : (word_val & ~(WB'(1) << bit_reg));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[word_reg] <= wr_word;
        end
        if (rd_en)
        begin
            rd_data_reg  <= mem[rd_addr];
            rd_valid_reg <= valid_reg[rd_addr];
            word_reg     <= word_next;
        end
        if (cmd.free_read)
        begin
            bit_reg <= page_frame[BW-1:0];
        end
        if (cmd.alloc_write)
        begin
            found_frame_reg <= {word_reg, found_bit};
        end
        if (cmd.out_load)
        begin
            frame_address_reg <= cmd.out_has_addr
                ? bfa_pkg::FADDR_W'({found_frame_reg, {bfa_pkg::FRAME_SHIFT{1'b0}}})
                : '0;
            status_reg        <= cmd.out_status;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg       <= '0;
            frame_count_reg <= bfa_pkg::FRAME_COUNT_RESET;
        end
        else
        begin
            if (cfg_write)
            begin
                frame_count_reg <= cfg_data;
            end
            if (cmd.clear_map)
            begin
                valid_reg <= '0;
            end
            else if (mem_we)
            begin
                valid_reg[word_reg] <= 1'b1;
            end
        end
    end

    assign frame_address = frame_address_reg;
    assign status        = status_reg;

endmodule

// File: rtl/core/bfa_controller.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator controller
// Sequences allocate, free and initialize operations and owns the request
// and response handshakes.
// ----------------------------------------------------------------------------
module bfa_controller (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    input  logic [bfa_pkg::KIND_W-1:0]    req_kind,
    output logic                          req_ready,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    input  bfa_pkg::bfa_stat_t            stat,
    output bfa_pkg::bfa_cmd_t             cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FREE_WR,
        S_DONE
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    logic [bfa_pkg::STATUS_W-1:0]  res_status_reg;
    logic [bfa_pkg::STATUS_W-1:0]  res_status_next;
    logic                          res_addr_reg;
    logic                          res_addr_next;
    logic                          accept;

    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = out_valid_reg;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        cmd             = '0;
        cmd.out_status  = res_status_reg;
        cmd.out_has_addr = res_addr_reg;
        state_next      = state_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_status_next = bfa_pkg::ST_OK;
                    res_addr_next   = 1'b0;
                    state_next      = S_DONE;
                    unique case (req_kind)
                        bfa_pkg::KIND_ALLOC:
                        begin
                            if (stat.limit_zero)
                            begin
                                res_status_next = bfa_pkg::ST_OOM;
                            end
                            else
                            begin
                                cmd.start_search = 1'b1;
                                state_next       = S_SCAN;
                            end
                        end
                        bfa_pkg::KIND_FREE:
                        begin
                            if (stat.free_in_range)
                            begin
                                cmd.free_read = 1'b1;
                                state_next    = S_FREE_WR;
                            end
                            else
                            begin
                                res_status_next = bfa_pkg::ST_RANGE;
                            end
                        end
                        bfa_pkg::KIND_INIT:
                        begin
                            cmd.clear_map = 1'b1;
                        end
                        default:
                        begin
                            res_status_next = bfa_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                priority if (stat.found)
                begin
                    cmd.alloc_write = 1'b1;
                    res_addr_next   = 1'b1;
                    state_next      = S_DONE;
                end
                else if (stat.last_word)
                begin
                    res_status_next = bfa_pkg::ST_OOM;
                    state_next      = S_DONE;
                end
                else
                begin
                    cmd.next_word = 1'b1;
                end
            end
            S_FREE_WR:
            begin
                cmd.free_write = 1'b1;
                state_next     = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            res_status_reg <= bfa_pkg::ST_OK;
            res_addr_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            res_status_reg <= res_status_next;
            res_addr_reg   <= res_addr_next;
        end
    end

endmodule

// File: rtl/core/bfa_checker.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator checker
// Port-level assertions on the request and response channels.
// ----------------------------------------------------------------------------
module bfa_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bfa_pkg::FADDR_W-1:0]   frame_address,
    input logic [bfa_pkg::STATUS_W-1:0]  status
);

    // Only one operation is in flight, so an accepted word closes the input.
    a_single_op: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while an operation is in flight");

    a_fail_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && status != bfa_pkg::ST_OK) |-> (frame_address == '0))
        else $error("failed response carries a frame address");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(frame_address)
                                       && $stable(status)))
        else $error("stalled response word changed");

    // A response word appears only while an input word is being worked on.
    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(!req_ready))
        else $error("response raised while the input was idle");

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .frame_address (rsp.frame_address),
    .status        (rsp.status)
);

// File: dv/tb.sv
// ----------------------------------------------------------------------------
// Bitmap frame allocator testbench
// Drives allocate, free, initialize and unused requests through the request
// channel, with random gaps and response stalls. Each request is run through
// a copy of the frame map kept here. Every response is checked against the
// oldest awaited one. The frame count is changed between phases while the
// block is idle, and covers zero, one, word edges, the full map and values
// above it.
// ----------------------------------------------------------------------------
module tb;

    localparam logic [bfa_pkg::KIND_W-1:0] KIND_NONE = 2'd3;
    localparam int LIMIT_CYCLES = 600000;
    localparam int RANDOM_WORDS = 700;

    typedef struct packed {
        logic [bfa_pkg::KIND_W-1:0] kind;
        logic [bfa_pkg::ADDR_W-1:0] address;
        logic                       drain;
    } req_word_t;

    typedef struct packed {
        logic [bfa_pkg::FADDR_W-1:0]  frame_address;
        logic [bfa_pkg::STATUS_W-1:0] status;
    } rsp_word_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_write;
    logic [bfa_pkg::COUNT_W-1:0] cfg_data;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();

    bitmap_frame_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_write (cfg_write),
        .cfg_data  (cfg_data)
    );

    logic [bfa_pkg::WORD_BITS-1:0] used_words [bfa_pkg::MAP_WORDS];
    logic [bfa_pkg::COUNT_W-1:0]   frame_count_q;

    req_word_t req_words [$];
    rsp_word_t awaited_rsp [$];

    bit        burst;
    int        send_wait;
    int        recv_wait;
    req_word_t next_word;
    rsp_word_t want;
    int        words_sent = 0;
    int        rsp_checked = 0;
    int        oom_seen = 0;
    int        range_seen = 0;
    int        error_count = 0;
    int        cycle_count = 0;
    int        phase_count;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic void clear_frame_map();
        for (int w = 0; w < bfa_pkg::MAP_WORDS; w++)
        begin
            used_words[w] = '0;
        end
        used_words[0][0] = 1'b1;
    endfunction

    function automatic int unsigned usable_frames(
        input logic [bfa_pkg::COUNT_W-1:0] count);
        return (count > bfa_pkg::MAX_FRAMES) ? bfa_pkg::MAX_FRAMES : count;
    endfunction

    function automatic rsp_word_t apply_request(input logic [bfa_pkg::KIND_W-1:0] kind,
                                                input logic [bfa_pkg::ADDR_W-1:0] address);
        rsp_word_t   r;
        int unsigned lim;
        int unsigned f;
        logic [bfa_pkg::ADDR_W-1:0] page;
        r.frame_address = '0;
        r.status        = bfa_pkg::ST_OK;
        lim = usable_frames(frame_count_q);
        case (kind)
            bfa_pkg::KIND_ALLOC:
            begin
                f = 0;
                while (f < lim && used_words[f / bfa_pkg::WORD_BITS][f % bfa_pkg::WORD_BITS])
                begin
                    f++;
                end
                if (f < lim)
                begin
                    used_words[f / bfa_pkg::WORD_BITS][f % bfa_pkg::WORD_BITS] = 1'b1;
                    r.frame_address = bfa_pkg::FADDR_W'(f * bfa_pkg::FRAME_BYTES);
                end
                else
                begin
                    r.status = bfa_pkg::ST_OOM;
                end
            end
            bfa_pkg::KIND_FREE:
            begin
                page = address >> bfa_pkg::FRAME_SHIFT;
                if (page < lim)
                begin
                    used_words[page / bfa_pkg::WORD_BITS][page % bfa_pkg::WORD_BITS] = 1'b0;
                end
                else
                begin
                    r.status = bfa_pkg::ST_RANGE;
                end
            end
            bfa_pkg::KIND_INIT:
            begin
                clear_frame_map();
            end
            default:
            begin
            end
        endcase
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] exp_val);
        $display("tb: mismatch in %s at response %0d: got 0x%0h, wanted 0x%0h",
                 what, rsp_checked, got, exp_val);
        error_count++;
    endtask

    task automatic queue_word(input logic [bfa_pkg::KIND_W-1:0] kind,
                              input logic [bfa_pkg::ADDR_W-1:0] address,
                              input logic drain);
        req_word_t w;
        w.kind    = kind;
        w.address = address;
        w.drain   = drain;
        req_words.push_back(w);
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (req_words.size() != 0 || req_ch.valid || awaited_rsp.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    task automatic set_frame_count(input logic [bfa_pkg::COUNT_W-1:0] count);
        wait_idle();
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= count;
        @(posedge clk);
        cfg_write <= 1'b0;
        frame_count_q = count;
        phase_count++;
        @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_ch.valid   <= 1'b0;
            req_ch.kind    <= bfa_pkg::KIND_ALLOC;
            req_ch.address <= '0;
            send_wait = 0;
        end
        else
        begin
            if (req_ch.valid && req_ch.ready)
            begin
                awaited_rsp.push_back(apply_request(req_ch.kind, req_ch.address));
                words_sent++;
                send_wait = burst ? 0 : $urandom_range(0, 4);
            end
            if (!req_ch.valid || req_ch.ready)
            begin
                if (send_wait > 0)
                begin
                    req_ch.valid <= 1'b0;
                    send_wait--;
                end
                else if (req_words.size() == 0 ||
                         (req_words[0].drain && awaited_rsp.size() != 0))
                begin
                    req_ch.valid <= 1'b0;
                end
                else
                begin
                    next_word = req_words.pop_front();
                    req_ch.valid   <= 1'b1;
                    req_ch.kind    <= next_word.kind;
                    req_ch.address <= next_word.address;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ch.ready <= 1'b0;
            recv_wait = 0;
        end
        else
        begin
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    report_mismatch("unawaited response", 32'(rsp_ch.status), 32'd0);
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp_ch.frame_address !== want.frame_address)
                    begin
                        report_mismatch("frame_address", 32'(rsp_ch.frame_address),
                                        32'(want.frame_address));
                    end
                    if (rsp_ch.status !== want.status)
                    begin
                        report_mismatch("status", 32'(rsp_ch.status), 32'(want.status));
                    end
                    if (want.status == bfa_pkg::ST_OOM)
                    begin
                        oom_seen++;
                    end
                    if (want.status == bfa_pkg::ST_RANGE)
                    begin
                        range_seen++;
                    end
                end
                rsp_checked++;
                recv_wait = burst ? 0 : $urandom_range(0, 4);
            end
            if (recv_wait > 0)
            begin
                rsp_ch.ready <= 1'b0;
                recv_wait--;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int unsigned pick;
        int unsigned n;
        int unsigned lim;
        int unsigned page;
        int          drain_at;
        int          random_sent;
        logic [bfa_pkg::COUNT_W-1:0] count_v;
        logic [bfa_pkg::KIND_W-1:0]  kind_v;
        logic [bfa_pkg::ADDR_W-1:0]  addr_v;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_data       = bfa_pkg::FRAME_COUNT_RESET;
        burst          = 1'b0;
        phase_count    = 0;
        random_sent    = 0;
        frame_count_q  = bfa_pkg::FRAME_COUNT_RESET;
        clear_frame_map();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset state: frame 0 is used and the full map is searched.
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'hFFFF_FFFF, 1'b0);
        queue_word(bfa_pkg::KIND_FREE,  32'h0000_0FFF, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_FREE,  32'hFFFF_FFFF, 1'b0);
        queue_word(bfa_pkg::KIND_FREE,  32'h00FF_F000, 1'b0);
        queue_word(bfa_pkg::KIND_FREE,  32'h0100_0000, 1'b0);
        queue_word(KIND_NONE,           32'hA5A5_5A5A, 1'b0);
        queue_word(bfa_pkg::KIND_INIT,  32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);

        set_frame_count(13'd0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_FREE,  32'h0000_0000, 1'b0);

        set_frame_count(13'd1);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_FREE,  32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);

        set_frame_count(13'd8191);
        queue_word(bfa_pkg::KIND_FREE,  32'h00FF_F123, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_FREE,  32'h1000_0000, 1'b0);

        set_frame_count(13'd2);
        queue_word(bfa_pkg::KIND_FREE,  32'h0000_1000, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);
        queue_word(bfa_pkg::KIND_ALLOC, 32'h0000_0000, 1'b0);

        while (random_sent < RANDOM_WORDS)
        begin
            pick = $urandom_range(0, 19);
            case (pick)
                0:       count_v = 13'd0;
                1:       count_v = 13'd1;
                2:       count_v = 13'd32;
                3:       count_v = 13'd33;
                4:       count_v = 13'd4096;
                5:       count_v = 13'd8191;
                6:       count_v = bfa_pkg::COUNT_W'($urandom_range(4097, 8191));
                default: count_v = bfa_pkg::COUNT_W'($urandom_range(2, 160));
            endcase
            set_frame_count(count_v);
            burst = ($urandom_range(0, 3) == 0);
            lim = usable_frames(count_v);
            n = $urandom_range(20, 70);
            drain_at = (random_sent == 0 || $urandom_range(0, 3) == 0)
                       ? $urandom_range(1, n - 1) : -1;
            if ($urandom_range(0, 2) == 0)
            begin
                queue_word(bfa_pkg::KIND_INIT, $urandom(), 1'b0);
            end
            for (int i = 0; i < n; i++)
            begin
                pick = $urandom_range(0, 99);
                addr_v = $urandom();
                if (pick < 55)
                begin
                    kind_v = bfa_pkg::KIND_ALLOC;
                end
                else if (pick < 80)
                begin
                    kind_v = bfa_pkg::KIND_FREE;
                    if (lim > 0)
                    begin
                        page = $urandom_range(0, lim - 1);
                        addr_v = (page << bfa_pkg::FRAME_SHIFT)
                                 | $urandom_range(0, bfa_pkg::FRAME_BYTES - 1);
                    end
                end
                else if (pick < 90)
                begin
                    kind_v = bfa_pkg::KIND_FREE;
                end
                else if (pick < 95)
                begin
                    kind_v = bfa_pkg::KIND_INIT;
                end
                else
                begin
                    kind_v = KIND_NONE;
                end
                queue_word(kind_v, addr_v, (i == drain_at));
            end
            random_sent += n;
        end

        wait_idle();
        repeat (150) @(posedge clk);
        if (awaited_rsp.size() != 0)
        begin
            report_mismatch("responses still awaited", 32'(awaited_rsp.size()), 32'd0);
        end

        $display("tb: %0d requests over %0d frame count settings, %0d responses checked",
                 words_sent, phase_count, rsp_checked);
        $display("tb: %0d out-of-memory and %0d out-of-range responses, %0d mismatches",
                 oom_seen, range_seen, error_count);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
